/* hdl/vrse_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vrse_pkg
// Shared types and fixed field widths of the voxel region sum engine.
// ----------------------------------------------------------------------------
package vrse_pkg;

  // fixed field widths of the item, configuration and result ports
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COORD_W = 5;
  localparam int unsigned DIM_W   = 6;
  localparam int unsigned REACH_W = 7;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned EDGE_W  = 6;
  localparam int unsigned SUM_W   = 48;

  // reset value of the edge register
  localparam logic [EDGE_W-1:0] EDGE_RESET = 6'd32;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BOX   = 2'd1,
    OP_TETRA = 2'd2,
    OP_BALL  = 2'd3
  } op_e;

endpackage : vrse_pkg
`default_nettype wire

/* hdl/voxel_region_sum_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_region_sum_engine
// Cubic voxel store with box, tetrahedron and ball octant region sums.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one item per transfer. A load item
//   writes one cell, a query item (box, tetrahedron, ball octant) returns one
//   region_sum_o on the output channel (out_valid_o / out_stall_i).
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes the cube edge; it
//   is always ready, and the user must write it only while the block is idle;
//   the block itself does not enforce this. A load passes through the load
//   state before the next item is taken. A query walks every offset triple of
//   the cube in use, one cell per cycle through the single read port of the
//   store, then passes the drain states before the result sits in the output
//   register; an edge of zero skips the walk and the drain states.
//   The block takes the next item as soon as the result has moved to the
//   output register; a stalled receiver holds that register, and a following
//   query then waits at its end until the register is free.
//   Reset sets the edge to 32 and empties the output register; the store
//   holds no defined contents until cells are loaded.
// ----------------------------------------------------------------------------
module voxel_region_sum_engine
  import vrse_pkg::*;
#(
  parameter int unsigned MAX_EDGE   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // configuration write channel
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire  [EDGE_W-1:0]         cfg_edge_size_i,
  // input item channel
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire  [OP_W-1:0]           op_i,
  input  wire  [COORD_W-1:0]        coord_level_i,
  input  wire  [COORD_W-1:0]        coord_column_i,
  input  wire  [COORD_W-1:0]        coord_panel_i,
  input  wire  [DIM_W-1:0]          box_height_i,
  input  wire  [DIM_W-1:0]          box_width_i,
  input  wire  [DIM_W-1:0]          box_depth_i,
  input  wire  [REACH_W-1:0]        reach_i,
  input  wire  signed [VALUE_W-1:0] cell_value_i,
  // result channel
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic signed [SUM_W-1:0]   region_sum_o
);

  localparam int unsigned CELLS = MAX_EDGE * MAX_EDGE * MAX_EDGE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned PW    = $clog2(MAX_EDGE);
  localparam logic [AW-1:0] ROW_STEP   = AW'(MAX_EDGE);
  localparam logic [AW-1:0] PLANE_STEP = AW'(MAX_EDGE * MAX_EDGE);
  localparam int unsigned SQ_W  = 2 * DIM_W;
  localparam int unsigned SSQ_W = 2 * REACH_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DRAIN1 = 3'd4;
  localparam logic [2:0] S_DRAIN2 = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // position of a cell along one axis, growing toward the cube center
  function automatic logic signed [8:0] axis_pos(input logic [COORD_W-1:0] crd,
                                                 input logic [DIM_W-1:0]   off,
                                                 input logic [EDGE_W-1:0]  len);
    logic signed [8:0] base;
    logic signed [8:0] step;
    logic              up;
    base = $signed({4'b0, crd});
    step = $signed({3'b0, off});
    up   = ({1'b0, crd} < (len >> 1));
    return up ? base + step : base - step;
  endfunction

  function automatic logic pos_inside(input logic signed [8:0] q,
                                      input logic [EDGE_W-1:0] len);
    return !q[8] && (q < $signed({3'b0, len}));
  endfunction

  // registers
  logic [2:0]               state_q, state_d;
  logic [EDGE_W-1:0]        edge_size_q;
  op_e                      op_q;
  logic [COORD_W-1:0]       lvl_q, col_q, pnl_q;
  logic [DIM_W-1:0]         height_q, width_q, depth_q;
  logic [REACH_W-1:0]       reach_q;
  logic [VALUE_BITS-1:0]    value_q;
  logic [SSQ_W-1:0]         reach_sq_q, reach_sq_d;
  logic [DIM_W-1:0]         a_q, a_d, b_q, b_d, c_q, c_d;
  logic [SQ_W-1:0]          a_sq_q, a_sq_d, b_sq_q, b_sq_d, c_sq_q, c_sq_d;
  logic                     s1_hit_q, s1_hit_d;
  logic [AW-1:0]            s1_addr_q;
  logic                     s2_hit_q;
  logic [VALUE_BITS-1:0]    rdata_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0]  region_sum_q;
  logic                     out_load;

  // combinational helpers
  logic [EDGE_W-1:0]        edge_len, edge_last;
  logic                     in_xfer;
  logic signed [8:0]        q_lvl, q_col, q_pnl;
  logic                     walk_inside, covered, load_inside;
  logic [PW-1:0]            pos_l, pos_v, pos_p;
  logic [AW-1:0]            cell_addr;
  logic [SSQ_W-1:0]         dist_sq;
  logic [DIM_W+1:0]         off_sum;

  logic [VALUE_BITS-1:0]    voxel_mem [CELLS];

  // edge in use, saturated to the store size
  always_comb begin
    if ((7'(edge_size_q) > 7'(MAX_EDGE))) begin
      edge_len = EDGE_W'(MAX_EDGE);
    end else begin
      edge_len = edge_size_q;
    end
    edge_last = edge_len - 6'd1;
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;

  // cell positions for the current offset triple
  assign q_lvl = axis_pos(lvl_q, a_q, edge_len);
  assign q_col = axis_pos(col_q, b_q, edge_len);
  assign q_pnl = axis_pos(pnl_q, c_q, edge_len);
  assign walk_inside = pos_inside(q_lvl, edge_len) && pos_inside(q_col, edge_len)
                       && pos_inside(q_pnl, edge_len);
  assign load_inside = ({1'b0, lvl_q} < edge_len) && ({1'b0, col_q} < edge_len)
                       && ({1'b0, pnl_q} < edge_len);

  // shape membership test
  assign off_sum = (DIM_W+2)'(a_q) + (DIM_W+2)'(b_q) + (DIM_W+2)'(c_q);
  assign dist_sq = SSQ_W'(a_sq_q) + SSQ_W'(b_sq_q) + SSQ_W'(c_sq_q);
  always_comb begin
    case (op_q)
      OP_BOX:   covered = (a_q <= height_q) && (b_q <= width_q) && (c_q <= depth_q);
      OP_TETRA: covered = (off_sum <= (DIM_W+2)'(reach_q));
      OP_BALL:  covered = (dist_sq <= reach_sq_q);
      default:  covered = 1'b0;
    endcase
  end

  // shared address unit: loaded cell or walked cell
  always_comb begin
    if (state_q == S_LOAD) begin
      pos_l = PW'(lvl_q);
      pos_v = PW'(col_q);
      pos_p = PW'(pnl_q);
    end else begin
      pos_l = PW'(q_lvl);
      pos_v = PW'(q_col);
      pos_p = PW'(q_pnl);
    end
    cell_addr = AW'(pos_l) * PLANE_STEP + AW'(pos_v) * ROW_STEP + AW'(pos_p);
  end

  // sequencer, offset counters and accumulator
  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    a_sq_d      = a_sq_q;
    b_sq_d      = b_sq_q;
    c_sq_d      = c_sq_q;
    reach_sq_d  = reach_sq_q;
    s1_hit_d    = 1'b0;
    acc_d       = acc_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    if (s2_hit_q) begin
      acc_d = acc_q + {{(SUM_W-VALUE_BITS){rdata_q[VALUE_BITS-1]}}, rdata_q};
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (op_e'(op_i) == OP_LOAD) ? S_LOAD : S_SETUP;
        end
      end
      S_LOAD: begin
        state_d = S_IDLE;
      end
      S_SETUP: begin
        a_d        = '0;
        b_d        = '0;
        c_d        = '0;
        a_sq_d     = '0;
        b_sq_d     = '0;
        c_sq_d     = '0;
        acc_d      = '0;
        reach_sq_d = SSQ_W'(reach_q) * SSQ_W'(reach_q);
        state_d    = (edge_len == '0) ? S_DONE : S_WALK;
      end
      S_WALK: begin
        s1_hit_d = walk_inside && covered;
        if (c_q != edge_last) begin
          c_d    = c_q + 6'd1;
          c_sq_d = c_sq_q + SQ_W'({c_q, 1'b1});
        end else begin
          c_d    = '0;
          c_sq_d = '0;
          if (b_q != edge_last) begin
            b_d    = b_q + 6'd1;
            b_sq_d = b_sq_q + SQ_W'({b_q, 1'b1});
          end else begin
            b_d    = '0;
            b_sq_d = '0;
            if (a_q != edge_last) begin
              a_d    = a_q + 6'd1;
              a_sq_d = a_sq_q + SQ_W'({a_q, 1'b1});
            end else begin
              state_d = S_DRAIN1;
            end
          end
        end
      end
      S_DRAIN1: begin
        state_d = S_DRAIN2;
      end
      S_DRAIN2: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      edge_size_q <= EDGE_RESET;
      s1_hit_q    <= 1'b0;
      s2_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_hit_q    <= s1_hit_d;
      s2_hit_q    <= s1_hit_q;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        edge_size_q <= cfg_edge_size_i;
      end
    end
  end

  // item capture on input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q     <= op_e'(op_i);
      lvl_q    <= coord_level_i;
      col_q    <= coord_column_i;
      pnl_q    <= coord_panel_i;
      height_q <= box_height_i;
      width_q  <= box_width_i;
      depth_q  <= box_depth_i;
      reach_q  <= reach_i;
      value_q  <= cell_value_i[VALUE_BITS-1:0];
    end
  end

  // walk datapath registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    a_sq_q     <= a_sq_d;
    b_sq_q     <= b_sq_d;
    c_sq_q     <= c_sq_d;
    reach_sq_q <= reach_sq_d;
    s1_addr_q  <= cell_addr;
    acc_q      <= acc_d;
    if (out_load) begin
      region_sum_q <= acc_q;
    end
  end

  // voxel store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if ((state_q == S_LOAD) && load_inside) begin
      voxel_mem[cell_addr] <= value_q;
    end
    rdata_q <= voxel_mem[s1_addr_q];
  end

  assign out_valid_o  = out_valid_q;
  assign region_sum_o = region_sum_q;

  // offset counters stay inside the cube while walking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (a_q < edge_len) && (b_q < edge_len) && (c_q < edge_len))
    else $error("offset counter beyond edge during walk");

  // running squares track the offsets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (a_sq_q == SQ_W'(a_q * a_q)) && (b_sq_q == SQ_W'(b_q * b_q))
                            && (c_sq_q == SQ_W'(c_q * c_q)))
    else $error("running square out of step with offset");

  // a cell read is only issued from the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_hit_q |-> ($past(state_q) == S_WALK))
    else $error("read issued outside the walk");

  // the read pipeline is empty once the result is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !s1_hit_q && !s2_hit_q)
    else $error("result taken before the pipeline drained");

  // a finished query reaches the output register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && !(out_valid_q && out_stall_i)
      |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished result not moved to the output register");

endmodule : voxel_region_sum_engine
`default_nettype wire
